>>> hw/rtl/hrhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrhp_pkg;

  // Counter width default and result field width
  localparam int unsigned CountBitsDefault = 32;
  localparam int unsigned OutWidth         = 32;

  // Key and status limits
  localparam logic [3:0] LenKeySize    = 4'd14;
  localparam logic [3:0] KeyPosMax     = 4'd15;
  localparam logic [9:0] StatusMax     = 10'd999;
  localparam logic [9:0] StatusSatFrom = 10'd99;

  // Character codes
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] CaseGap = 8'h20;

  // Parser phase, one-hot
  typedef enum logic [10:0] {
    PhNone   = 11'b000_0000_0001,
    PhMajor  = 11'b000_0000_0010,
    PhMinor  = 11'b000_0000_0100,
    PhCode   = 11'b000_0000_1000,
    PhReason = 11'b000_0001_0000,
    PhCr     = 11'b000_0010_0000,
    PhEol    = 11'b000_0100_0000,
    PhKey    = 11'b000_1000_0000,
    PhValue  = 11'b001_0000_0000,
    PhCr2    = 11'b010_0000_0000,
    PhBody   = 11'b100_0000_0000
  } phase_e;

  // Reported phase codes
  localparam logic [3:0] PhaseCodeNone   = 4'd0;
  localparam logic [3:0] PhaseCodeMajor  = 4'd1;
  localparam logic [3:0] PhaseCodeMinor  = 4'd2;
  localparam logic [3:0] PhaseCodeCode   = 4'd3;
  localparam logic [3:0] PhaseCodeReason = 4'd4;
  localparam logic [3:0] PhaseCodeCr     = 4'd5;
  localparam logic [3:0] PhaseCodeEol    = 4'd6;
  localparam logic [3:0] PhaseCodeKey    = 4'd7;
  localparam logic [3:0] PhaseCodeValue  = 4'd8;
  localparam logic [3:0] PhaseCodeCr2    = 4'd9;
  localparam logic [3:0] PhaseCodeBody   = 4'd10;

  // Header value scan mode, one-hot
  typedef enum logic [3:0] {
    VmSkip = 4'b0001,
    VmPos  = 4'b0010,
    VmNeg  = 4'b0100,
    VmStop = 4'b1000
  } value_mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
    logic       new_response;
  } item_t;

  typedef struct packed {
    logic [3:0]          phase;
    logic [9:0]          status_value;
    logic [OutWidth-1:0] length_value;
    logic                body_valid;
    logic [7:0]          body_byte;
    logic [OutWidth-1:0] body_count;
    logic                done_flag;
  } result_t;

  function automatic logic [3:0] phase_code(phase_e p);
    logic [3:0] code;
    case (p)
      PhNone:   code = PhaseCodeNone;
      PhMajor:  code = PhaseCodeMajor;
      PhMinor:  code = PhaseCodeMinor;
      PhCode:   code = PhaseCodeCode;
      PhReason: code = PhaseCodeReason;
      PhCr:     code = PhaseCodeCr;
      PhEol:    code = PhaseCodeEol;
      PhKey:    code = PhaseCodeKey;
      PhValue:  code = PhaseCodeValue;
      PhCr2:    code = PhaseCodeCr2;
      PhBody:   code = PhaseCodeBody;
      default:  code = PhaseCodeNone;
    endcase
    return code;
  endfunction

  // Content-Length key, upper case, by position
  function automatic logic [7:0] len_key_char(logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = "C";
      4'd1:    ch = "O";
      4'd2:    ch = "N";
      4'd3:    ch = "T";
      4'd4:    ch = "E";
      4'd5:    ch = "N";
      4'd6:    ch = "T";
      4'd7:    ch = "-";
      4'd8:    ch = "L";
      4'd9:    ch = "E";
      4'd10:   ch = "N";
      4'd11:   ch = "G";
      4'd12:   ch = "T";
      4'd13:   ch = "H";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_digit(c) || ((c >= ChUpA) && (c <= ChUpZ)) ||
           ((c >= ChLowA) && (c <= ChLowZ));
  endfunction

  function automatic logic [7:0] fold(logic [7:0] c);
    return ((c >= ChLowA) && (c <= ChLowZ)) ? (c - CaseGap) : c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hrhp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;
  logic       new_response;

  modport source (output valid, output data_byte, output chunk_end, output new_response,
                  input ready);
  modport sink (input valid, input data_byte, input chunk_end, input new_response,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hrhp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hrhp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  phase;
  logic [9:0]  status_value;
  logic [31:0] length_value;
  logic        body_valid;
  logic [7:0]  body_byte;
  logic [31:0] body_count;
  logic        done_flag;

  modport source (output valid, output phase, output status_value, output length_value,
                  output body_valid, output body_byte, output body_count,
                  output done_flag, input ready);
  modport sink (input valid, input phase, input status_value, input length_value,
                input body_valid, input body_byte, input body_count, input done_flag,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/http_response_header_parser.sv
// Channel | Dir | Payload                                              | Handshake
// in_i    | in  | data_byte, chunk_end, new_response                   | valid/ready
// out_o   | out | phase, status_value, length_value, body_valid,       | valid/ready
//         |     | body_byte, body_count, done_flag                     |
//
// One byte per cycle sustained while the output is ready; a taken request passes
// through the input register, then the parser step, into the result register.
// The parser state advances as a byte moves from the input register into the
// result register. Reset clears both valid flags and all parser state.
// A stalled result holds; the input register still takes one more request.
`timescale 1ns / 1ps
`default_nettype none

module http_response_header_parser #(
  parameter int unsigned COUNT_BITS = hrhp_pkg::CountBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrhp_in_if.sink    in_i,
  hrhp_out_if.source out_o
);

  hrhp_pkg::item_t   item_in;
  hrhp_pkg::item_t   item_q;
  hrhp_pkg::result_t result_d;
  hrhp_pkg::result_t result_q;
  logic              item_valid;
  logic              load_ready;
  logic              advance;

  assign item_in.data_byte    = in_i.data_byte;
  assign item_in.chunk_end    = in_i.chunk_end;
  assign item_in.new_response = in_i.new_response;

  // Move a byte through the parser when the result register is free
  assign advance = item_valid && load_ready;

  hrhp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .ready_o   (in_i.ready),
    .item_i    (item_in),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item_q)
  );

  hrhp_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .result_o  (result_d)
  );

  hrhp_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance),
    .result_i     (result_d),
    .load_ready_o (load_ready),
    .valid_o      (out_o.valid),
    .ready_i      (out_o.ready),
    .result_o     (result_q)
  );

  assign out_o.phase        = result_q.phase;
  assign out_o.status_value = result_q.status_value;
  assign out_o.length_value = result_q.length_value;
  assign out_o.body_valid   = result_q.body_valid;
  assign out_o.body_byte    = result_q.body_byte;
  assign out_o.body_count   = result_q.body_count;
  assign out_o.done_flag    = result_q.done_flag;

endmodule

`default_nettype wire

>>> hw/rtl/hrhp_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module hrhp_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  hrhp_pkg::item_t item_i,
  input  logic            advance_i,
  output logic            valid_o,
  output hrhp_pkg::item_t item_o
);

  logic            valid_q;
  logic            valid_d;
  hrhp_pkg::item_t item_q;
  logic            accept;

  // Take a request when empty or when the held one moves on this cycle
  assign ready_o = !valid_q || advance_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until replaced
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  // A held request is never dropped without moving on
  a_hold_until_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !advance_i |=> valid_q)
    else $error("input request lost without advance");

endmodule

`default_nettype wire

>>> hw/rtl/hrhp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module hrhp_core #(
  parameter int unsigned COUNT_BITS = hrhp_pkg::CountBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  hrhp_pkg::item_t   item_i,
  output hrhp_pkg::result_t result_o
);

  localparam int unsigned WideW = COUNT_BITS + 4;
  localparam int unsigned ExtW  = (COUNT_BITS > hrhp_pkg::OutWidth) ?
                                  COUNT_BITS : hrhp_pkg::OutWidth;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // Parser state
  hrhp_pkg::phase_e      phase_q, phase_d;
  logic [9:0]            status_q, status_d;
  logic [3:0]            key_pos_q, key_pos_d;
  logic                  len_match_q, len_match_d;
  logic [COUNT_BITS-1:0] value_q, value_d;
  hrhp_pkg::value_mode_e mode_q, mode_d;
  logic [COUNT_BITS-1:0] length_q, length_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [15:0]           last_two_q, last_two_d;

  // State as seen by this byte, after an optional restart
  hrhp_pkg::phase_e      cur_phase;
  logic [9:0]            cur_status;
  logic [3:0]            cur_key_pos;
  logic                  cur_len_match;
  logic [COUNT_BITS-1:0] cur_value;
  hrhp_pkg::value_mode_e cur_mode;
  logic [COUNT_BITS-1:0] cur_length;
  logic [COUNT_BITS-1:0] cur_count;
  logic [15:0]           cur_last_two;

  logic [7:0]            c;
  logic [3:0]            digit;
  logic                  value_space;
  logic [9:0]            status_x10;
  logic [COUNT_BITS-1:0] acc_base;
  logic [WideW-1:0]      acc_wide;
  logic [COUNT_BITS-1:0] acc_next;
  logic                  body;
  logic [ExtW-1:0]       length_ext;
  logic [ExtW-1:0]       count_ext;

  assign c      = item_i.data_byte;
  assign digit  = 4'(c - hrhp_pkg::ChZero);

  assign cur_phase     = item_i.new_response ? hrhp_pkg::PhNone : phase_q;
  assign cur_status    = item_i.new_response ? 10'd0 : status_q;
  assign cur_key_pos   = item_i.new_response ? 4'd0 : key_pos_q;
  assign cur_len_match = item_i.new_response ? 1'b1 : len_match_q;
  assign cur_value     = item_i.new_response ? '0 : value_q;
  assign cur_mode      = item_i.new_response ? hrhp_pkg::VmSkip : mode_q;
  assign cur_length    = item_i.new_response ? '0 : length_q;
  assign cur_count     = item_i.new_response ? '0 : count_q;
  assign cur_last_two  = item_i.new_response ? 16'd0 : last_two_q;

  // Status digit step, valid while the code stays at two digits or fewer
  assign status_x10 = {cur_status[6:0], 3'b000} + {cur_status[8:0], 1'b0};

  // Value digit step: acc * 10 + d, saturating at the counter limit
  assign value_space = hrhp_pkg::is_blank(c) || (c == hrhp_pkg::ChLf) ||
                       (c == hrhp_pkg::ChVt) || (c == hrhp_pkg::ChFf);
  assign acc_base = (cur_mode == hrhp_pkg::VmSkip) ? '0 : cur_value;
  assign acc_wide = ({4'b0000, acc_base} << 3) + ({4'b0000, acc_base} << 1) +
                    WideW'(digit);
  assign acc_next = (acc_wide[WideW-1:COUNT_BITS] != 4'd0) ? CountMax :
                    acc_wide[COUNT_BITS-1:0];

  // Next state for one byte
  always_comb begin
    phase_d     = cur_phase;
    status_d    = cur_status;
    key_pos_d   = cur_key_pos;
    len_match_d = cur_len_match;
    value_d     = cur_value;
    mode_d      = cur_mode;
    length_d    = cur_length;
    count_d     = cur_count;
    last_two_d  = cur_last_two;
    body        = 1'b0;
    case (cur_phase)
      hrhp_pkg::PhNone: begin
        if (c == hrhp_pkg::ChSlash) phase_d = hrhp_pkg::PhMajor;
      end
      hrhp_pkg::PhMajor: begin
        if (c == hrhp_pkg::ChDot) phase_d = hrhp_pkg::PhMinor;
      end
      hrhp_pkg::PhMinor: begin
        if (hrhp_pkg::is_blank(c)) begin
          phase_d  = hrhp_pkg::PhCode;
          status_d = 10'd0;
        end
      end
      hrhp_pkg::PhCode: begin
        if (hrhp_pkg::is_digit(c)) begin
          status_d = (cur_status > hrhp_pkg::StatusSatFrom) ? hrhp_pkg::StatusMax :
                     (status_x10 + 10'(digit));
        end else if (hrhp_pkg::is_blank(c)) begin
          phase_d = hrhp_pkg::PhReason;
        end
      end
      hrhp_pkg::PhReason: begin
        if (c == hrhp_pkg::ChCr) phase_d = hrhp_pkg::PhCr;
      end
      hrhp_pkg::PhCr: begin
        if (c == hrhp_pkg::ChLf) phase_d = hrhp_pkg::PhEol;
      end
      hrhp_pkg::PhEol: begin
        if (hrhp_pkg::is_alnum(c)) begin
          phase_d     = hrhp_pkg::PhKey;
          key_pos_d   = 4'd1;
          len_match_d = (hrhp_pkg::fold(c) == hrhp_pkg::len_key_char(4'd0));
        end else if (c == hrhp_pkg::ChCr) begin
          phase_d = hrhp_pkg::PhCr2;
        end
      end
      hrhp_pkg::PhKey: begin
        if (hrhp_pkg::is_blank(c) || (c == hrhp_pkg::ChColon)) begin
          phase_d = hrhp_pkg::PhValue;
          value_d = '0;
          mode_d  = hrhp_pkg::VmSkip;
        end else begin
          if ((cur_key_pos < hrhp_pkg::LenKeySize) &&
              (hrhp_pkg::fold(c) != hrhp_pkg::len_key_char(cur_key_pos))) begin
            len_match_d = 1'b0;
          end
          if (cur_key_pos != hrhp_pkg::KeyPosMax) key_pos_d = cur_key_pos + 4'd1;
        end
      end
      hrhp_pkg::PhValue: begin
        if (c == hrhp_pkg::ChCr) begin
          if (cur_len_match && (cur_key_pos >= hrhp_pkg::LenKeySize)) begin
            length_d = (cur_mode == hrhp_pkg::VmPos) ? cur_value : '0;
          end
          phase_d = hrhp_pkg::PhCr;
        end else begin
          case (cur_mode)
            hrhp_pkg::VmSkip: begin
              if (!value_space) begin
                if (c == hrhp_pkg::ChPlus) begin
                  mode_d = hrhp_pkg::VmPos;
                end else if (c == hrhp_pkg::ChMinus) begin
                  mode_d = hrhp_pkg::VmNeg;
                end else if (hrhp_pkg::is_digit(c)) begin
                  mode_d  = hrhp_pkg::VmPos;
                  value_d = acc_next;
                end else begin
                  mode_d = hrhp_pkg::VmStop;
                end
              end
            end
            hrhp_pkg::VmPos: begin
              if (hrhp_pkg::is_digit(c)) value_d = acc_next;
              else mode_d = hrhp_pkg::VmStop;
            end
            hrhp_pkg::VmNeg: begin
              if (!hrhp_pkg::is_digit(c)) mode_d = hrhp_pkg::VmStop;
            end
            default: ;
          endcase
        end
      end
      hrhp_pkg::PhCr2: begin
        if (c == hrhp_pkg::ChLf) phase_d = hrhp_pkg::PhBody;
      end
      hrhp_pkg::PhBody: begin
        body       = 1'b1;
        count_d    = (cur_count == CountMax) ? cur_count : (cur_count + 1'b1);
        last_two_d = {cur_last_two[7:0], c};
        if (item_i.chunk_end && (last_two_d == {hrhp_pkg::ChCr, hrhp_pkg::ChLf}) &&
            (count_d >= COUNT_BITS'(2))) begin
          length_d = count_d;
        end
      end
      default: ;
    endcase
  end

  // Advance state with the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hrhp_pkg::PhNone;
      status_q    <= 10'd0;
      key_pos_q   <= 4'd0;
      len_match_q <= 1'b1;
      value_q     <= '0;
      mode_q      <= hrhp_pkg::VmSkip;
      length_q    <= '0;
      count_q     <= '0;
      last_two_q  <= 16'd0;
    end else if (advance_i) begin
      phase_q     <= phase_d;
      status_q    <= status_d;
      key_pos_q   <= key_pos_d;
      len_match_q <= len_match_d;
      value_q     <= value_d;
      mode_q      <= mode_d;
      length_q    <= length_d;
      count_q     <= count_d;
      last_two_q  <= last_two_d;
    end
  end

  // Result of this byte
  assign length_ext = ExtW'(length_d);
  assign count_ext  = ExtW'(count_d);

  always_comb begin
    result_o.phase        = hrhp_pkg::phase_code(phase_d);
    result_o.status_value = ((phase_d == hrhp_pkg::PhNone) ||
                             (phase_d == hrhp_pkg::PhMajor) ||
                             (phase_d == hrhp_pkg::PhMinor) ||
                             (phase_d == hrhp_pkg::PhCode)) ? 10'd0 : status_d;
    result_o.length_value = length_ext[hrhp_pkg::OutWidth-1:0];
    result_o.body_valid   = body;
    result_o.body_byte    = body ? c : 8'd0;
    result_o.body_count   = count_ext[hrhp_pkg::OutWidth-1:0];
    result_o.done_flag    = (length_d != '0) && (length_d == count_d);
  end

  a_status_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q <= hrhp_pkg::StatusMax)
    else $error("status above limit");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !item_i.new_response |=> count_q >= $past(count_q))
    else $error("body count went backwards");

  a_body_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !item_i.new_response && (phase_q == hrhp_pkg::PhBody)
    |=> phase_q == hrhp_pkg::PhBody)
    else $error("left body without restart");

  a_body_only_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && result_o.body_valid |=> phase_q == hrhp_pkg::PhBody)
    else $error("body byte outside body phase");

endmodule

`default_nettype wire

>>> hw/rtl/hrhp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module hrhp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hrhp_pkg::result_t result_i,
  output logic              load_ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output hrhp_pkg::result_t result_o
);

  logic              valid_q;
  logic              valid_d;
  hrhp_pkg::result_t result_q;

  // Free when empty or when the held result is taken now
  assign load_ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire
